// File: hdl/mdfs_pkg.sv
package mdfs_pkg;

  // command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_START_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_TABLE = 3'd4;

  // register reset values
  localparam logic [2:0]  RST_START_X   = 3'd0;
  localparam logic [2:0]  RST_START_Y   = 3'd0;
  localparam logic [2:0]  RST_END_X     = 3'd7;
  localparam logic [2:0]  RST_END_Y     = 3'd7;
  localparam logic [15:0] RST_DIR_TABLE = 16'h341C;

  // search constants
  localparam int DIR_COUNT   = 4;
  localparam int DIR_W       = 3;
  localparam int MAX_RESULTS = 64;

  typedef struct packed {
    logic       command;
    logic [2:0] cell_row;
    logic [2:0] cell_col;
    logic       cell_open;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [2:0] path_x;
    logic [2:0] path_y;
    logic       last;
  } out_item_t;

endpackage

// File: hdl/mdfs_nbr.sv
module mdfs_nbr #(
  parameter int GRID_HEIGHT = 8,
  parameter int GRID_WIDTH  = 8
) (
  input  logic [$clog2(GRID_WIDTH)-1:0]                x,
  input  logic [$clog2(GRID_HEIGHT)-1:0]               y,
  input  logic [3:0]                                   nibble,
  output logic [$clog2(GRID_WIDTH)-1:0]                nx,
  output logic [$clog2(GRID_HEIGHT)-1:0]               ny,
  output logic                                         in_grid,
  output logic [$clog2(GRID_HEIGHT*GRID_WIDTH)-1:0]    idx
);

  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);
  localparam int CW    = $clog2(GRID_HEIGHT * GRID_WIDTH);
  localparam int MW    = (XW > YW) ? XW : YW;
  localparam int NW    = ((MW > 3) ? MW : 3) + 2;

  logic [NW-1:0] sx;
  logic [NW-1:0] sy;

  // two's complement add of the sign-extended offsets
  assign sx = NW'(x) + {{(NW-2){nibble[1]}}, nibble[1:0]};
  assign sy = NW'(y) + {{(NW-2){nibble[3]}}, nibble[3:2]};

  assign in_grid = !sx[NW-1] && (sx < NW'(GRID_WIDTH))
                && !sy[NW-1] && (sy < NW'(GRID_HEIGHT));

  assign nx  = sx[XW-1:0];
  assign ny  = sy[YW-1:0];
  assign idx = CW'(sy) * CW'(GRID_WIDTH) + CW'(sx);

endmodule

// File: hdl/maze_dfs_path_finder.sv
// depth-first path search on a grid maze, one command per transfer
// input channel: a transfer happens at a clock edge with start high and busy low
//   load command: writes one maze cell (if in the grid), busy stays low, no result
//   run command: searches from the start to the end register and emits the path
// result channel: out_valid marks each result for exactly one cycle; the receiver
//   cannot stall, so results go out on a fixed schedule
//   path results come end cell first, last set on the start cell
//   no path, or start outside the grid: one result with found=0 and last=1
// run steps: a visited-map clearing pass of GRID_HEIGHT*GRID_WIDTH cells, then
//   in-grid neighbor tries (memory read, then check), off-grid tries with no read,
//   stack pops (stack read, then restore) and path cells emitted (stack read, then
//   output); registered reads of the maze, visited and stack memories set this
// configuration: plain write port, taken any time the block is idle
// reset (synchronous, active low): registers to defaults, block idle; maze cells
//   are undefined until loaded and must all be loaded before a run
module maze_dfs_path_finder #(
  parameter int GRID_HEIGHT = 8,
  parameter int GRID_WIDTH  = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  mdfs_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  output mdfs_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [mdfs_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [mdfs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int CELLS = GRID_HEIGHT * GRID_WIDTH;
  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);
  localparam int CW    = $clog2(CELLS);
  localparam int DW    = $clog2(CELLS + 1);
  localparam int MW    = (XW > YW) ? XW : YW;
  localparam int NW    = ((MW > 3) ? MW : 3) + 2;
  localparam int SEW   = XW + YW + mdfs_pkg::DIR_W;
  localparam int NMAX  = (CELLS < mdfs_pkg::MAX_RESULTS) ? CELLS : mdfs_pkg::MAX_RESULTS;

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CLEAR    = 4'd1;
  localparam logic [3:0] S_TRY      = 4'd2;
  localparam logic [3:0] S_CHECK    = 4'd3;
  localparam logic [3:0] S_GOAL     = 4'd4;
  localparam logic [3:0] S_POPW     = 4'd5;
  localparam logic [3:0] S_EMIT_RD  = 4'd6;
  localparam logic [3:0] S_EMIT_OUT = 4'd7;

  function automatic logic [CW-1:0] cell_idx(input logic [NW-1:0] yy, input logic [NW-1:0] xx);
    cell_idx = CW'(yy) * CW'(GRID_WIDTH) + CW'(xx);
  endfunction

  // control and configuration registers
  logic [3:0]          state_r, state_nxt;
  logic [2:0]          start_x_r, start_y_r, end_x_r, end_y_r;
  logic [15:0]         dir_table_r;
  logic [XW-1:0]       x_r, x_nxt;
  logic [YW-1:0]       y_r, y_nxt;
  logic [mdfs_pkg::DIR_W-1:0] dir_r, dir_nxt;
  logic [DW-1:0]       depth_r, depth_nxt;
  logic [CW-1:0]       clr_r, clr_nxt;
  logic [DW-1:0]       k_r, k_nxt;
  logic                out_valid_r, out_valid_nxt;
  mdfs_pkg::out_item_t out_data_r, out_data_nxt;

  // memories: maze map, visited map, path stack of {x, y, next direction}
  logic          maze_mem [CELLS];
  logic          vis_mem  [CELLS];
  logic [SEW-1:0] stk_mem [CELLS];
  logic          maze_rd_r;
  logic          vis_rd_r;
  logic [SEW-1:0] stk_rd_r;

  logic           maze_we;
  logic [CW-1:0]  maze_waddr;
  logic           vis_we;
  logic [CW-1:0]  vis_waddr;
  logic           vis_wdata;
  logic           stk_we;
  logic [CW-1:0]  stk_waddr;
  logic [SEW-1:0] stk_wdata;
  logic [DW-1:0]  stk_rptr;

  // neighbor of the current cell in the current direction
  logic [XW-1:0]  nb_x;
  logic [YW-1:0]  nb_y;
  logic           nb_in_grid;
  logic [CW-1:0]  nb_idx;
  logic [3:0]     nibble;

  logic           accept;
  logic           load_in_grid;
  logic           start_in_grid;
  logic           nb_goal;
  logic [DW-1:0]  emit_n;
  logic [XW-1:0]  e_x;
  logic [YW-1:0]  e_y;
  logic [mdfs_pkg::DIR_W-1:0] e_dir;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign nibble = dir_table_r[dir_r[1:0]*4 +: 4];

  mdfs_nbr #(
    .GRID_HEIGHT (GRID_HEIGHT),
    .GRID_WIDTH  (GRID_WIDTH)
  ) u_nbr (
    .x       (x_r),
    .y       (y_r),
    .nibble  (nibble),
    .nx      (nb_x),
    .ny      (nb_y),
    .in_grid (nb_in_grid),
    .idx     (nb_idx)
  );

  assign load_in_grid  = (NW'(in_data.cell_row) < NW'(GRID_HEIGHT))
                      && (NW'(in_data.cell_col) < NW'(GRID_WIDTH));
  assign start_in_grid = (NW'(start_x_r) < NW'(GRID_WIDTH))
                      && (NW'(start_y_r) < NW'(GRID_HEIGHT));
  assign nb_goal       = (NW'(nb_x) == NW'(end_x_r)) && (NW'(nb_y) == NW'(end_y_r));

  // path length emitted, capped at the result limit
  assign emit_n = (depth_r > DW'(NMAX)) ? DW'(NMAX) : depth_r;

  assign {e_x, e_y, e_dir} = stk_rd_r;

  // stack read pointer: top of stack on a pop, walking down during emit
  assign stk_rptr = (state_r == S_EMIT_RD) ? (depth_r - DW'(1) - k_r) : (depth_r - DW'(1));

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    dir_nxt       = dir_r;
    depth_nxt     = depth_r;
    clr_nxt       = clr_r;
    k_nxt         = k_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    maze_we       = 1'b0;
    maze_waddr    = cell_idx(NW'(in_data.cell_row), NW'(in_data.cell_col));
    vis_we        = 1'b0;
    vis_waddr     = cell_idx(NW'(y_r), NW'(x_r));
    vis_wdata     = 1'b1;
    stk_we        = 1'b0;
    stk_waddr     = depth_r[CW-1:0];
    stk_wdata     = {x_r, y_r, dir_r + mdfs_pkg::DIR_W'(1)};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.command == mdfs_pkg::CMD_LOAD) begin
            maze_we = load_in_grid;
          end else if (!start_in_grid) begin
            // start off the grid: answer no path at once
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{found: 1'b0, path_x: 3'd0, path_y: 3'd0, last: 1'b1};
          end else begin
            x_nxt     = XW'(start_x_r);
            y_nxt     = YW'(start_y_r);
            dir_nxt   = '0;
            depth_nxt = '0;
            clr_nxt   = '0;
            state_nxt = S_CLEAR;
          end
        end
      end

      S_CLEAR: begin
        // one visited entry cleared per cycle
        vis_we    = 1'b1;
        vis_waddr = clr_r;
        vis_wdata = 1'b0;
        clr_nxt   = clr_r + CW'(1);
        if (clr_r == CW'(CELLS - 1)) begin
          state_nxt = S_TRY;
        end
      end

      S_TRY: begin
        if (dir_r == mdfs_pkg::DIR_W'(mdfs_pkg::DIR_COUNT)) begin
          if (depth_r == '0) begin
            // stack empty: no path
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{found: 1'b0, path_x: 3'd0, path_y: 3'd0, last: 1'b1};
            state_nxt     = S_IDLE;
          end else begin
            depth_nxt = depth_r - DW'(1);
            state_nxt = S_POPW;
          end
        end else if (!nb_in_grid) begin
          dir_nxt = dir_r + mdfs_pkg::DIR_W'(1);
        end else begin
          // maze and visited read at the neighbor, checked next cycle
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        if (maze_rd_r && !vis_rd_r) begin
          if (depth_r < DW'(CELLS)) begin
            stk_we    = 1'b1;
            depth_nxt = depth_r + DW'(1);
          end
          vis_we  = 1'b1;
          x_nxt   = nb_x;
          y_nxt   = nb_y;
          dir_nxt = '0;
          state_nxt = nb_goal ? S_GOAL : S_TRY;
        end else begin
          dir_nxt   = dir_r + mdfs_pkg::DIR_W'(1);
          state_nxt = S_TRY;
        end
      end

      S_GOAL: begin
        // goal cell goes on the stack as the first cell emitted
        stk_wdata = {x_r, y_r, mdfs_pkg::DIR_W'(0)};
        if (depth_r < DW'(CELLS)) begin
          stk_we    = 1'b1;
          depth_nxt = depth_r + DW'(1);
        end
        k_nxt     = '0;
        state_nxt = S_EMIT_RD;
      end

      S_POPW: begin
        x_nxt     = e_x;
        y_nxt     = e_y;
        dir_nxt   = e_dir;
        state_nxt = S_TRY;
      end

      S_EMIT_RD: begin
        state_nxt = S_EMIT_OUT;
      end

      S_EMIT_OUT: begin
        out_valid_nxt       = 1'b1;
        out_data_nxt.found  = 1'b1;
        out_data_nxt.path_x = 3'(e_x);
        out_data_nxt.path_y = 3'(e_y);
        out_data_nxt.last   = (k_r == emit_n - DW'(1));
        if (k_r == emit_n - DW'(1)) begin
          depth_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = k_r + DW'(1);
          state_nxt = S_EMIT_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
      start_x_r   <= mdfs_pkg::RST_START_X;
      start_y_r   <= mdfs_pkg::RST_START_Y;
      end_x_r     <= mdfs_pkg::RST_END_X;
      end_y_r     <= mdfs_pkg::RST_END_Y;
      dir_table_r <= mdfs_pkg::RST_DIR_TABLE;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          mdfs_pkg::REG_START_X:   start_x_r   <= cfg_wdata[2:0];
          mdfs_pkg::REG_START_Y:   start_y_r   <= cfg_wdata[2:0];
          mdfs_pkg::REG_END_X:     end_x_r     <= cfg_wdata[2:0];
          mdfs_pkg::REG_END_Y:     end_y_r     <= cfg_wdata[2:0];
          mdfs_pkg::REG_DIR_TABLE: dir_table_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    dir_r      <= dir_nxt;
    clr_r      <= clr_nxt;
    k_r        <= k_nxt;
    out_data_r <= out_data_nxt;
  end

  // maze map
  always_ff @(posedge clk) begin
    if (maze_we) begin
      maze_mem[maze_waddr] <= in_data.cell_open;
    end
    maze_rd_r <= maze_mem[nb_idx];
  end

  // visited map
  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_rd_r <= vis_mem[nb_idx];
  end

  // path stack
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_r <= stk_mem[stk_rptr[CW-1:0]];
  end

endmodule

// File: hdl/mdfs_checker.sv
module mdfs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input mdfs_pkg::in_item_t  in_data,
  input logic                out_valid,
  input mdfs_pkg::out_item_t out_data
);

  // a no-path answer is always the single, final result
  a_nopath_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.last)
    else $error("no-path result without last");

  a_nopath_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> (out_data.path_x == 3'd0) && (out_data.path_y == 3'd0))
    else $error("no-path result with nonzero cell");

  // a load transfer leaves the block idle and gives no result
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.command == mdfs_pkg::CMD_LOAD) |=> !busy && !out_valid)
    else $error("load caused busy or a result");

  // the final result frees the block; earlier ones come while it is busy
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> !busy)
    else $error("busy after final result");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> busy)
    else $error("intermediate result while idle");

endmodule

bind maze_dfs_path_finder mdfs_checker u_mdfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
